FILE: rtl/srd_pkg.sv
`timescale 1ns / 1ps

package srd_pkg;

  // Sizing of the step counters and the hold time
  localparam int COUNT_WIDTH = 15;
  localparam int DELAY_WIDTH = 16;

  // Fixed widths of the register fields and the step count field
  localparam int REG_W    = 16;
  localparam int ACCEL_W  = 12;
  localparam int RAMP_W   = ACCEL_W + 1;
  localparam int STEP_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Signed working width of the hold-time arithmetic
  localparam int HOLD_CALC_W = ((DELAY_WIDTH > REG_W) ? DELAY_WIDTH : REG_W) + 2;

  // Register reset values
  localparam logic [REG_W-1:0]   BASE_DELAY_RST = 16'd4000;
  localparam logic [ACCEL_W-1:0] ACCEL_STEP_RST = 12'd200;
  localparam logic [REG_W-1:0]   MIN_DELAY_RST  = 16'd2400;
  localparam logic [REG_W-1:0]   MAX_DELAY_RST  = 16'd4000;

  // Coil pattern per phase, two coils on, bit k drives pin k
  localparam logic [3:0] COIL_TABLE [4] = '{4'h9, 4'h3, 4'h6, 4'hC};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_DELAY = 2'd0,
    REG_ACCEL_STEP = 2'd1,
    REG_MIN_DELAY  = 2'd2,
    REG_MAX_DELAY  = 2'd3
  } srd_reg_e;

  typedef struct packed {
    logic [REG_W-1:0]   base_delay;
    logic [ACCEL_W-1:0] accel_step;
    logic [REG_W-1:0]   min_delay;
    logic [REG_W-1:0]   max_delay;
  } srd_cfg_t;

endpackage

FILE: rtl/srd_hold_calc.sv
`timescale 1ns / 1ps

// Next hold time: previous value plus ramp, clamp to min then max, saturate.
module srd_hold_calc import srd_pkg::*; (
  input  srd_cfg_t                        cfg_i,
  input  logic signed [HOLD_CALC_W-1:0]   prev_i,
  input  logic signed [RAMP_W-1:0]        ramp_i,
  output logic        [DELAY_WIDTH-1:0]   hold_o
);

  localparam logic signed [HOLD_CALC_W-1:0] DelayMax =
    HOLD_CALC_W'((64'd1 << DELAY_WIDTH) - 64'd1);

  logic signed [HOLD_CALC_W-1:0] sum;
  logic signed [HOLD_CALC_W-1:0] min_ext;
  logic signed [HOLD_CALC_W-1:0] max_ext;
  logic signed [HOLD_CALC_W-1:0] lo_clamped;
  logic signed [HOLD_CALC_W-1:0] hi_clamped;
  logic signed [HOLD_CALC_W-1:0] saturated;

  assign sum = prev_i + {{(HOLD_CALC_W-RAMP_W){ramp_i[RAMP_W-1]}}, ramp_i};
  assign min_ext = {{(HOLD_CALC_W-REG_W){1'b0}}, cfg_i.min_delay};
  assign max_ext = {{(HOLD_CALC_W-REG_W){1'b0}}, cfg_i.max_delay};

  // The max clamp comes last, so it wins when min is above max
  assign lo_clamped = (sum <= min_ext) ? min_ext : sum;
  assign hi_clamped = (lo_clamped >= max_ext) ? max_ext : lo_clamped;
  assign saturated  = (hi_clamped > DelayMax) ? DelayMax : hi_clamped;
  assign hold_o     = saturated[DELAY_WIDTH-1:0];

endmodule

FILE: rtl/stepper_full_step_ramp_driver.sv
`timescale 1ns / 1ps

// Two-motor full-step stepper sequencer with an acceleration ramp. Each input
// transfer is either a one-microsecond tick (tuser = 0) or a move command
// (tuser = 1) carrying a signed step count and a motor select; every input
// transfer yields exactly one output transfer with both motors' coil levels,
// the busy flag after that item, and a reject flag for a move that arrived
// while a move was still running. A move writes pin 0 of its first step at
// once; each following pin is written on the tick that ends the hold of the
// previous one, and busy drops on the tick that ends pin 3 of the last step.
// The hold time starts at base_delay - 2*accel_step, falls by accel_step per
// step until count/5, holds until 4*count/5, then rises, clamped to
// [min_delay, max_delay] (max wins). Step counts saturate to 2^15 - 1.
// Rate: one item per clock cycle sustained while the result stream is not
// stalled; each item passes an input register and then a result register,
// which offers the result on the output stream. The per-item work
// (hold-time add and clamp, phase and pin update, one constant multiply for
// count/5) fits between these two registers.
// Configuration writes take effect at the next clock edge; base_delay is only
// read when a move starts.
module stepper_full_step_ramp_driver import srd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // [15:0] step_count, [16] motor_select
  input  logic                 s_axis_tuser,  // [0] cmd
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata   // [3:0] coils_first, [7:4] coils_second,
                                              // [8] busy_res, [9] rejected
);

  localparam int MagW = (COUNT_WIDTH > STEP_W) ? COUNT_WIDTH : STEP_W;
  localparam logic [MagW-1:0] CountMax = MagW'({COUNT_WIDTH{1'b1}});
  // Reciprocal of 5, exact for every count value
  localparam int Div5Shift = COUNT_WIDTH + 2;
  localparam int Div5Mult  = ((2 ** Div5Shift) + 4) / 5;
  localparam int ProdW     = 2 * COUNT_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  srd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_delay <= BASE_DELAY_RST;
      cfg_q.accel_step <= ACCEL_STEP_RST;
      cfg_q.min_delay  <= MIN_DELAY_RST;
      cfg_q.max_delay  <= MAX_DELAY_RST;
    end else if (cfg_we_i) begin
      case (srd_reg_e'(cfg_idx_i))
        REG_BASE_DELAY: cfg_q.base_delay <= cfg_data_i;
        REG_ACCEL_STEP: cfg_q.accel_step <= cfg_data_i[ACCEL_W-1:0];
        REG_MIN_DELAY:  cfg_q.min_delay  <= cfg_data_i;
        REG_MAX_DELAY:  cfg_q.max_delay  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and result register handshake
  // ---------------------------------------------------------------------------
  logic              in_valid_q;
  logic              in_cmd_q;
  logic [STEP_W-1:0] in_count_q;
  logic              in_motor_q;
  logic              out_valid_q;
  logic [15:0]       out_data_q;
  logic              advance;

  // Move the held item into the result register whenever that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q   <= s_axis_tuser;
      in_count_q <= s_axis_tdata[STEP_W-1:0];
      in_motor_q <= s_axis_tdata[STEP_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [1:0]              phase_first_q, phase_first_d;
  logic [1:0]              phase_second_q, phase_second_d;
  logic [3:0]              coils_first_q, coils_first_d;
  logic [3:0]              coils_second_q, coils_second_d;
  logic signed [RAMP_W-1:0] ramp_q, ramp_d;
  logic [DELAY_WIDTH-1:0]  hold_q, hold_d;
  logic [COUNT_WIDTH-1:0]  steps_done_q, steps_done_d;
  logic [COUNT_WIDTH-1:0]  steps_total_q, steps_total_d;
  logic [COUNT_WIDTH-1:0]  cruise_q, cruise_d;
  logic [COUNT_WIDTH-1:0]  decel_q, decel_d;
  logic [1:0]              pin_q, pin_d;
  logic [DELAY_WIDTH-1:0]  wait_q, wait_d;
  logic                    backward_q, backward_d;
  logic                    active_q, active_d;
  logic                    moving_q, moving_d;

  // Step count magnitude, saturated to the counter range
  logic [STEP_W-1:0]      cnt_abs;
  logic [MagW-1:0]        cnt_wide;
  logic [COUNT_WIDTH-1:0] mag;
  logic [ProdW-1:0]       div_prod;
  logic [COUNT_WIDTH-1:0] quot5;
  logic [COUNT_WIDTH-1:0] quot5_x5;
  logic [2:0]             rem5;
  logic [COUNT_WIDTH-1:0] decel_new;

  assign cnt_abs  = in_count_q[STEP_W-1] ? (~in_count_q + STEP_W'(1)) : in_count_q;
  assign cnt_wide = MagW'(cnt_abs);
  assign mag      = (cnt_wide > CountMax) ? COUNT_WIDTH'(CountMax)
                                          : COUNT_WIDTH'(cnt_wide);

  // count/5 by reciprocal; 4*count/5 = 4*q + (r == 0 ? 0 : r - 1)
  assign div_prod  = ProdW'(mag) * ProdW'(Div5Mult);
  assign quot5     = COUNT_WIDTH'(div_prod >> Div5Shift);
  assign quot5_x5  = COUNT_WIDTH'({quot5, 2'b00}) + quot5;
  assign rem5      = 3'(mag - quot5_x5);
  assign decel_new = COUNT_WIDTH'({quot5, 2'b00})
                   + COUNT_WIDTH'((rem5 == 3'd0) ? 3'd0 : (rem5 - 3'd1));

  logic signed [RAMP_W-1:0]      neg_accel;
  logic signed [RAMP_W-1:0]      pos_accel;
  logic [COUNT_WIDTH-1:0]        sd_inc;
  logic                          start_step;
  logic                          do_write;
  logic                          cruise_hit;
  logic                          decel_hit;
  logic signed [RAMP_W-1:0]      cur_ramp;
  logic signed [RAMP_W-1:0]      step_ramp;
  logic signed [HOLD_CALC_W-1:0] prev_hold;
  logic [DELAY_WIDTH-1:0]        new_hold;
  logic [1:0]                    pin_phase;
  logic                          pin_bit;
  logic                          rejected;

  assign pos_accel = {1'b0, cfg_q.accel_step};
  assign neg_accel = -pos_accel;
  assign sd_inc    = steps_done_q + COUNT_WIDTH'(1);
  assign step_ramp = decel_hit ? pos_accel : (cruise_hit ? '0 : cur_ramp);

  srd_hold_calc u_hold_calc (
    .cfg_i  (cfg_q),
    .prev_i (prev_hold),
    .ramp_i (step_ramp),
    .hold_o (new_hold)
  );

  always_comb begin
    phase_first_d  = phase_first_q;
    phase_second_d = phase_second_q;
    coils_first_d  = coils_first_q;
    coils_second_d = coils_second_q;
    ramp_d         = ramp_q;
    hold_d         = hold_q;
    steps_done_d   = steps_done_q;
    steps_total_d  = steps_total_q;
    cruise_d       = cruise_q;
    decel_d        = decel_q;
    pin_d          = pin_q;
    wait_d         = wait_q;
    backward_d     = backward_q;
    active_d       = active_q;
    moving_d       = moving_q;
    rejected       = 1'b0;
    start_step     = 1'b0;
    do_write       = 1'b0;
    cruise_hit     = 1'b0;
    decel_hit      = 1'b0;
    cur_ramp       = ramp_q;
    prev_hold      = {{(HOLD_CALC_W-DELAY_WIDTH){1'b0}}, hold_q};
    pin_phase      = 2'd0;
    pin_bit        = 1'b0;

    if (advance) begin
      if (!in_cmd_q) begin
        // Tick: count down the hold, then advance pin, then advance step
        if (moving_q) begin
          if (wait_q > DELAY_WIDTH'(1)) begin
            wait_d = wait_q - DELAY_WIDTH'(1);
          end else if (pin_q != 2'd3) begin
            pin_d    = pin_q + 2'd1;
            do_write = 1'b1;
            wait_d   = hold_q;
          end else begin
            steps_done_d = sd_inc;
            if (sd_inc >= steps_total_q) begin
              moving_d = 1'b0;
              wait_d   = '0;
              pin_d    = 2'd0;
              ramp_d   = neg_accel;
            end else begin
              start_step = 1'b1;
              cruise_hit = (sd_inc == cruise_q);
              decel_hit  = (sd_inc == decel_q);
            end
          end
        end
      end else if (moving_q) begin
        rejected = 1'b1;
      end else begin
        backward_d = in_count_q[STEP_W-1];
        active_d   = in_motor_q;
        ramp_d     = neg_accel;
        if (mag != '0) begin
          steps_total_d = mag;
          steps_done_d  = '0;
          cruise_d      = quot5;
          decel_d       = decel_new;
          moving_d      = 1'b1;
          start_step    = 1'b1;
          cur_ramp      = neg_accel;
          // First step compares step 0 against count/5 and 4*count/5
          cruise_hit    = (mag < COUNT_WIDTH'(5));
          decel_hit     = (mag < COUNT_WIDTH'(2));
          prev_hold     = {{(HOLD_CALC_W-REG_W){1'b0}}, cfg_q.base_delay}
                        - {{(HOLD_CALC_W-ACCEL_W){1'b0}}, cfg_q.accel_step};
        end
      end

      if (start_step) begin
        ramp_d = step_ramp;
        if (active_d) begin
          phase_second_d = backward_d ? (phase_second_q - 2'd1) : (phase_second_q + 2'd1);
        end else begin
          phase_first_d = backward_d ? (phase_first_q - 2'd1) : (phase_first_q + 2'd1);
        end
        hold_d   = new_hold;
        wait_d   = new_hold;
        pin_d    = 2'd0;
        do_write = 1'b1;
      end

      // Drive the selected pin to its level for the current phase
      if (do_write) begin
        pin_phase = active_d ? phase_second_d : phase_first_d;
        pin_bit   = COIL_TABLE[pin_phase][pin_d];
        if (active_d) begin
          coils_second_d[pin_d] = pin_bit;
        end else begin
          coils_first_d[pin_d] = pin_bit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_first_q  <= '0;
      phase_second_q <= '0;
      coils_first_q  <= '0;
      coils_second_q <= '0;
      ramp_q         <= '0;
      hold_q         <= '0;
      steps_done_q   <= '0;
      steps_total_q  <= '0;
      cruise_q       <= '0;
      decel_q        <= '0;
      pin_q          <= '0;
      wait_q         <= '0;
      backward_q     <= 1'b0;
      active_q       <= 1'b0;
      moving_q       <= 1'b0;
    end else begin
      phase_first_q  <= phase_first_d;
      phase_second_q <= phase_second_d;
      coils_first_q  <= coils_first_d;
      coils_second_q <= coils_second_d;
      ramp_q         <= ramp_d;
      hold_q         <= hold_d;
      steps_done_q   <= steps_done_d;
      steps_total_q  <= steps_total_d;
      cruise_q       <= cruise_d;
      decel_q        <= decel_d;
      pin_q          <= pin_d;
      wait_q         <= wait_d;
      backward_q     <= backward_d;
      active_q       <= active_d;
      moving_q       <= moving_d;
    end
  end

  // Result payload: levels and flags after this item
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, rejected, moving_d, coils_second_d, coils_first_d};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !moving_q |-> (wait_q == '0) && (pin_q == 2'd0))
    else $error("idle sequencer holds a pending pin or wait");

  a_steps_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (steps_done_q < steps_total_q))
    else $error("step counter ran past the move length");

  a_wait_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (wait_q <= hold_q))
    else $error("hold countdown exceeds the hold time");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[9] |-> out_data_q[8])
    else $error("rejected move reported without busy");

  a_other_motor_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_cmd_q && moving_q && active_q |=> $stable(coils_first_q))
    else $error("tick disturbed the coils of the idle motor");

endmodule
